[rtl/srp_pkg.sv]
// Shared types, codes and constants of the skyline rectangle packer.
package srp_pkg;

	localparam int MAX_COLUMNS_DEF = 512;

	localparam int PW_W   = 10;
	localparam int PH_W   = 13;
	localparam int PL_W   = 9;
	localparam int PAGE_W = 8;
	localparam int RW_W   = 10;
	localparam int RH_W   = 13;
	localparam int CFG_DW = 13;
	localparam int CFG_IW = 2;

	localparam logic [PW_W-1:0]   PAGE_WIDTH_RST  = 10'd128;
	localparam logic [PH_W-1:0]   PAGE_HEIGHT_RST = 13'd128;
	localparam logic [PL_W-1:0]   PAGE_LIMIT_RST  = 9'd128;
	localparam logic [PAGE_W-1:0] FIRST_PAGE      = 8'd1;

	localparam logic ACT_PLACE = 1'b0;
	localparam logic ACT_BEGIN = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_LIMIT   = 2'd1;
	localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_PAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_PAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_PAGE_LIMIT  = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SETUP,
		S_BACK,
		S_GAP,
		S_FWD,
		S_FEND,
		S_EVAL,
		S_WRITE,
		S_DONE
	} srp_state_t;

	typedef enum logic [1:0] {
		CLR_INIT,
		CLR_BEGIN,
		CLR_RETRY
	} clr_mode_t;

endpackage

[rtl/srp_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
module srp_ram import srp_pkg::*; #(
	parameter int DEPTH = MAX_COLUMNS_DEF,
	parameter int DW    = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/skyline_rectangle_packer.sv]
// Skyline bottom-left rectangle packer: page control, skyline scan and write-back.
//
// Input channel (in_valid/in_stall) carries one request: action, req_width, req_height.
// A place request puts a rectangle on the current page at the lowest skyline window,
// leftmost on ties; a begin request clears the skyline and restarts at page 1.
// Output channel (out_valid/out_stall) returns one result per request: status, page,
// pos_x, pos_y and new_page. Registers page_width, page_height and page_limit are
// written through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle; the block itself does not enforce this. One request is in work at
// a time; in_stall is low only while the block is idle, including while an earlier
// result still waits in the output register. A placed rectangle is scanned and written
// back in passes: the column memory is read once per cycle in a backward pass
// that builds block suffix maxima and a forward pass that forms each window maximum, then
// the chosen columns are rewritten one per cycle. Opening a new page adds a clearing
// sweep over all MAX_COLUMNS columns and a second scan. A begin request runs the sweep.
// The block is idle again in the same cycle as a result appears and can take the next
// request in that cycle. After reset the block clears every column of the memory,
// stalling requests meanwhile. When the receiver stalls, the result holds and the block
// finishes no further request until it is taken.
module skyline_rectangle_packer import srp_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [RW_W-1:0]   req_width,
	input  logic [RH_W-1:0]   req_height,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [PAGE_W-1:0] page,
	output logic [8:0]        pos_x,
	output logic [11:0]       pos_y,
	output logic              new_page
);

	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int XW = ((CW > RW_W) ? CW : RW_W) + 1;
	localparam logic [AW-1:0] LAST_COL = AW'(MAX_COLUMNS - 1);

	function automatic logic [RH_W-1:0] hmax(input logic [RH_W-1:0] a,
		input logic [RH_W-1:0] b);
		hmax = (a > b) ? a : b;
	endfunction

	srp_state_t st_q, st_d;
	clr_mode_t  clr_mode_q;

	logic [PW_W-1:0]   pw_q;
	logic [PH_W-1:0]   ph_q;
	logic [PL_W-1:0]   pl_q;
	logic [PAGE_W-1:0] cur_page_q;
	logic [AW-1:0]     k_q;
	logic              b_v_s1, f_v_s1;
	logic              out_valid_q;

	logic [RW_W-1:0] w_q;
	logic [RH_W-1:0] h_q;
	logic [CW-1:0]   width_q;
	logic [RW_W-1:0] blk_q;
	logic [RH_W-1:0] best_q, sfx_q, pfx_q;
	logic [AW-1:0]   bx_q;
	logic            found_q, retry_q;
	logic [1:0]      res_status_q;
	logic            b_end_s1;
	logic [AW-1:0]   b_k_s1;
	logic            f_start_s1, f_win_s1;
	logic [AW-1:0]   f_i_s1;

	logic [1:0]        status_q;
	logic [PAGE_W-1:0] page_q;
	logic [8:0]        pos_x_q;
	logic [11:0]       pos_y_q;
	logic              new_page_q;

	// memory ports
	logic            col_we;
	logic [AW-1:0]   col_waddr;
	logic [RH_W-1:0] col_wdata, col_rdata;
	logic [AW-1:0]   suf_raddr;
	logic [RH_W-1:0] sfx, pfx, wmax, suf_rdata;

	// derived values
	logic [XW-1:0]   w_x, width_x, k_x, eff_width;
	logic [PL_W-1:0] next_page;
	logic [RH_W:0]   top_new;
	logic            fits, at_limit, scan_ok, fwd_last, fwd_win, accept, out_free;

	assign eff_width = (XW'(pw_q) < XW'(MAX_COLUMNS)) ? XW'(pw_q) : XW'(MAX_COLUMNS);
	assign w_x       = XW'(w_q);
	assign width_x   = XW'(width_q);
	assign k_x       = XW'(k_q);
	assign fwd_last  = (k_x + XW'(2)) == width_x;
	assign fwd_win   = (k_x + XW'(1)) >= w_x;
	assign suf_raddr = AW'(k_x + XW'(1) - w_x);
	assign scan_ok   = (w_q != '0) && (w_x < width_x);
	assign top_new   = {1'b0, best_q} + {1'b0, h_q};
	assign fits      = found_q && (top_new <= {1'b0, ph_q});
	assign next_page = PL_W'({1'b0, cur_page_q} + 9'd1);
	assign at_limit  = next_page == pl_q;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign sfx  = b_end_s1 ? col_rdata : hmax(col_rdata, sfx_q);
	assign pfx  = f_start_s1 ? col_rdata : hmax(col_rdata, pfx_q);
	assign wmax = hmax(pfx, suf_rdata);

	srp_ram #(.DEPTH(MAX_COLUMNS), .DW(RH_W)) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.raddr (k_q),
		.rdata (col_rdata)
	);

	srp_ram #(.DEPTH(MAX_COLUMNS), .DW(RH_W)) u_suf_ram (
		.clk   (clk),
		.we    (b_v_s1),
		.waddr (b_k_s1),
		.wdata (sfx),
		.raddr (suf_raddr),
		.rdata (suf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		col_we    = 1'b0;
		col_waddr = k_q;
		col_wdata = '0;
		case (st_q)
			S_CLEAR: begin
				col_we = 1'b1;
				if (k_q == LAST_COL) begin
					case (clr_mode_q)
						CLR_INIT:  st_d = S_IDLE;
						CLR_BEGIN: st_d = S_DONE;
						default:   st_d = S_SETUP;
					endcase
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					st_d = (action == ACT_BEGIN) ? S_CLEAR : S_SETUP;
				end
			end
			S_SETUP: st_d = scan_ok ? S_BACK : S_EVAL;
			S_BACK: begin
				if (k_q == '0) begin
					st_d = S_GAP;
				end
			end
			S_GAP: st_d = S_FWD;
			S_FWD: begin
				if (fwd_last) begin
					st_d = S_FEND;
				end
			end
			S_FEND: st_d = S_EVAL;
			S_EVAL: begin
				if (fits) begin
					st_d = (w_q == '0) ? S_DONE : S_WRITE;
				end else if (retry_q || at_limit) begin
					st_d = S_DONE;
				end else begin
					st_d = S_CLEAR;
				end
			end
			S_WRITE: begin
				col_we    = 1'b1;
				col_wdata = top_new[RH_W-1:0];
				if (blk_q == RW_W'(1)) begin
					st_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q        <= PAGE_WIDTH_RST;
			ph_q        <= PAGE_HEIGHT_RST;
			pl_q        <= PAGE_LIMIT_RST;
			cur_page_q  <= FIRST_PAGE;
			clr_mode_q  <= CLR_INIT;
			k_q         <= '0;
			b_v_s1      <= 1'b0;
			f_v_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PAGE_WIDTH:  pw_q <= cfg_data[PW_W-1:0];
					CFG_PAGE_HEIGHT: ph_q <= cfg_data[PH_W-1:0];
					CFG_PAGE_LIMIT:  pl_q <= cfg_data[PL_W-1:0];
					default: ;
				endcase
			end
			b_v_s1 <= (st_q == S_BACK);
			f_v_s1 <= (st_q == S_FWD);
			if (st_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_CLEAR: k_q <= k_q + AW'(1);
				S_IDLE: begin
					if (accept && action == ACT_BEGIN) begin
						clr_mode_q <= CLR_BEGIN;
						cur_page_q <= FIRST_PAGE;
						k_q        <= '0;
					end
				end
				S_SETUP: begin
					if (scan_ok) begin
						k_q <= AW'(width_x - XW'(1));
					end
				end
				S_BACK: begin
					if (k_q != '0) begin
						k_q <= k_q - AW'(1);
					end
				end
				S_GAP: k_q <= '0;
				S_FWD: k_q <= k_q + AW'(1);
				S_EVAL: begin
					if (fits) begin
						k_q <= bx_q;
					end else if (!retry_q && !at_limit) begin
						// close the page and retry on a cleared one
						cur_page_q <= next_page[PAGE_W-1:0];
						clr_mode_q <= CLR_RETRY;
						k_q        <= '0;
					end
				end
				S_WRITE: k_q <= k_q + AW'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (b_v_s1) begin
			sfx_q <= sfx;
		end
		if (f_v_s1) begin
			pfx_q <= pfx;
			if (f_win_s1 && wmax < best_q) begin
				best_q  <= wmax;
				bx_q    <= f_i_s1;
				found_q <= 1'b1;
			end
		end
		b_end_s1   <= (blk_q == '0);
		b_k_s1     <= k_q;
		f_start_s1 <= (blk_q == w_q - RW_W'(1)) || (k_q == '0);
		f_win_s1   <= fwd_win;
		f_i_s1     <= suf_raddr;
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					w_q          <= req_width;
					h_q          <= req_height;
					width_q      <= CW'(eff_width);
					retry_q      <= 1'b0;
					res_status_q <= STATUS_OK;
					bx_q         <= '0;
					best_q       <= '0;
				end
			end
			S_SETUP: begin
				blk_q <= '0;
				if (w_q == '0) begin
					// every start is valid at top zero: the last one wins
					found_q <= (width_q != '0);
					bx_q    <= AW'(width_x - XW'(1));
					best_q  <= '0;
				end else begin
					found_q <= 1'b0;
					bx_q    <= '0;
					best_q  <= ph_q;
				end
			end
			S_BACK: begin
				// block boundaries run from the right end, w columns apart
				if (k_q != '0) begin
					blk_q <= (blk_q == w_q - RW_W'(1)) ? '0 : blk_q + RW_W'(1);
				end
			end
			S_FWD: blk_q <= (blk_q == '0) ? w_q - RW_W'(1) : blk_q - RW_W'(1);
			S_EVAL: begin
				if (fits) begin
					blk_q <= w_q;
				end else if (retry_q) begin
					res_status_q <= STATUS_TOO_BIG;
				end else if (at_limit) begin
					res_status_q <= STATUS_LIMIT;
				end else begin
					retry_q <= 1'b1;
				end
			end
			S_WRITE: blk_q <= blk_q - RW_W'(1);
			S_DONE: begin
				if (out_free) begin
					status_q <= res_status_q;
					if (res_status_q == STATUS_OK) begin
						page_q     <= cur_page_q;
						pos_x_q    <= 9'(bx_q);
						pos_y_q    <= best_q[11:0];
						new_page_q <= retry_q;
					end else begin
						page_q     <= '0;
						pos_x_q    <= '0;
						pos_y_q    <= '0;
						new_page_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign page      = page_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign new_page  = new_page_q;

	a_rose_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == S_DONE))
		else $error("result appeared outside the completion step");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q != S_IDLE))
		else $error("accepted request did not start work");

	a_best_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EVAL && found_q) |-> (XW'(bx_q) < width_x))
		else $error("chosen start column outside the page");

	a_write_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_WRITE) |-> (k_x < width_x))
		else $error("skyline write beyond the page width");

	a_page_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cur_page_q) |-> $past(st_q == S_EVAL || st_q == S_IDLE))
		else $error("page counter changed outside evaluate or begin");

endmodule

[tb/skyline_rectangle_packer_tb.sv]
// Self-checking testbench for the skyline rectangle packer: predictor plus result scoreboard.
`timescale 1ns / 100ps

module skyline_rectangle_packer_tb;
	import srp_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 38;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] page;
		logic [8:0]        pos_x;
		logic [11:0]       pos_y;
		logic              new_page;
	} placement_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic              action;
	logic [RW_W-1:0]   req_width;
	logic [RH_W-1:0]   req_height;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [PAGE_W-1:0] page;
	logic [8:0]        pos_x;
	logic [11:0]       pos_y;
	logic              new_page;

	// predictor state
	logic [PW_W-1:0]   cfg_page_width;
	logic [PH_W-1:0]   cfg_page_height;
	logic [PL_W-1:0]   cfg_page_limit;
	logic [PH_W-1:0]   skyline [MAX_COLUMNS_DEF];
	logic [PAGE_W-1:0] page_now;

	placement_t placements_due[$];
	placement_t due_now;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	bit         steady = 1'b0;

	skyline_rectangle_packer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.req_width(req_width),
		.req_height(req_height),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.page(page),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.new_page(new_page)
	);

	always #5 clk = ~clk;

	function automatic void clear_skyline();
		foreach (skyline[k]) skyline[k] = '0;
	endfunction

	// Lowest window top wins, leftmost on ties; start columns stop short of the page width.
	function automatic bit fit_rectangle(input int unsigned w, input int unsigned h,
			output int unsigned px, output int unsigned py);
		int unsigned span, best, bx, top, c, i, j, raised;
		bit ok, found;
		span = 32'(cfg_page_width);
		if (span > MAX_COLUMNS_DEF) span = MAX_COLUMNS_DEF;
		best = 32'(cfg_page_height);
		bx = 0;
		found = 1'b0;
		px = 0;
		py = 0;
		if (w < span) begin
			for (i = 0; i < span - w; i++) begin
				top = 0;
				ok = 1'b1;
				for (j = 0; j < w; j++) begin
					if (ok) begin
						c = 32'(skyline[i + j]);
						if (c >= best) ok = 1'b0;
						else if (c > top) top = c;
					end
				end
				if (ok) begin
					bx = i;
					best = top;
					found = 1'b1;
				end
			end
		end
		if (!found || best + h > cfg_page_height) return 1'b0;
		raised = best + h;
		for (i = 0; i < w; i++) skyline[bx + i] = raised[PH_W-1:0];
		px = bx;
		py = best;
		return 1'b1;
	endfunction

	function automatic placement_t predict_placement(input logic act, input int unsigned w,
			input int unsigned h);
		placement_t r;
		int unsigned x, y;
		logic [8:0] nxt;
		r = '0;
		if (act == ACT_BEGIN) begin
			clear_skyline();
			page_now = FIRST_PAGE;
			r.page = FIRST_PAGE;
		end else if (fit_rectangle(w, h, x, y)) begin
			r.page = page_now;
			r.pos_x = x[8:0];
			r.pos_y = y[11:0];
		end else begin
			nxt = {1'b0, page_now} + 9'd1;
			if (nxt == cfg_page_limit) begin
				r.status = STATUS_LIMIT;
			end else begin
				// close the page and retry once on a fresh one
				page_now = nxt[PAGE_W-1:0];
				clear_skyline();
				if (fit_rectangle(w, h, x, y)) begin
					r.page = page_now;
					r.pos_x = x[8:0];
					r.pos_y = y[11:0];
					r.new_page = 1'b1;
				end else begin
					r.status = STATUS_TOO_BIG;
				end
			end
		end
		return r;
	endfunction

	task automatic send_request(input logic act, input logic [RW_W-1:0] w,
			input logic [RH_W-1:0] h);
		while (!steady && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		req_width <= w;
		req_height <= h;
		do @(posedge clk); while (in_stall);
		placements_due.push_back(predict_placement(act, 32'(w), 32'(h)));
	endtask

	// Hold off new requests until every outstanding result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (placements_due.size() != 0);
	endtask

	task automatic program_page(input int unsigned w, input int unsigned h,
			input int unsigned lim);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PAGE_WIDTH;
		cfg_data <= w[CFG_DW-1:0];
		@(posedge clk);
		cfg_index <= CFG_PAGE_HEIGHT;
		cfg_data <= h[CFG_DW-1:0];
		@(posedge clk);
		cfg_index <= CFG_PAGE_LIMIT;
		cfg_data <= lim[CFG_DW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_page_width = w[PW_W-1:0];
		cfg_page_height = h[PH_W-1:0];
		cfg_page_limit = lim[PL_W-1:0];
	endtask

	task automatic test_reset_defaults();
		send_request(ACT_PLACE, 10'd127, 13'd1);
		send_request(ACT_PLACE, 10'd1, 13'd128);
		send_request(ACT_PLACE, 10'd128, 13'd1);
	endtask

	task automatic test_begin_request();
		send_request(ACT_BEGIN, 10'd512, 13'd4096);
		send_request(ACT_BEGIN, 10'd0, 13'd0);
	endtask

	task automatic test_special_cases();
		program_page(16, 8, 4);
		send_request(ACT_PLACE, 10'd0, 13'd5);
		send_request(ACT_PLACE, 10'd15, 13'd0);
		send_request(ACT_PLACE, 10'd16, 13'd0);
		send_request(ACT_PLACE, 10'd4, 13'd3);
		send_request(ACT_PLACE, 10'd4, 13'd1);
		send_request(ACT_PLACE, 10'd8, 13'd8);
		send_request(ACT_PLACE, 10'd8, 13'd8);
	endtask

	task automatic test_extremes();
		program_page(512, 4096, 256);
		send_request(ACT_BEGIN, 10'd1, 13'd1);
		send_request(ACT_PLACE, 10'd511, 13'd4095);
		send_request(ACT_PLACE, 10'd511, 13'd1);
		send_request(ACT_PLACE, 10'd512, 13'd1);
		send_request(ACT_PLACE, 10'd1, 13'd4096);
		send_request(ACT_PLACE, 10'd0, 13'd1);
		program_page(1, 1, 2);
		send_request(ACT_BEGIN, 10'd300, 13'd2000);
		send_request(ACT_PLACE, 10'd1, 13'd1);
		send_request(ACT_PLACE, 10'd0, 13'd1);
	endtask

	// One rectangle per page drives the page counter up to its top and around.
	task automatic test_page_wrap();
		program_page(2, 1, 256);
		send_request(ACT_BEGIN, 10'd1, 13'd1);
		while (page_now != 8'd255) send_request(ACT_PLACE, 10'd1, 13'd1);
		send_request(ACT_PLACE, 10'd1, 13'd1);
		program_page(2, 1, 2);
		repeat (3) send_request(ACT_PLACE, 10'd1, 13'd1);
	endtask

	task automatic test_random_traffic();
		int unsigned pw, ph, lim, wmax, hmax, pick;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					pw = 512;
					ph = 4096;
					lim = 256;
				end
				1: begin
					pw = $urandom_range(1, 7);
					ph = $urandom_range(1, 8);
					lim = 2;
				end
				default: begin
					pw = $urandom_range(8, 64);
					ph = $urandom_range(4, 512);
					lim = $urandom_range(3, 256);
				end
			endcase
			program_page(pw, ph, lim);
			steady = (p == 3);
			wmax = (pw > 1) ? ((p == 0) ? pw / 4 : pw - 1) : 1;
			hmax = (ph >= 4) ? ph / 4 : 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == PHASE_ITEMS / 2) settle();
				pick = $urandom_range(99);
				if (pick < 5)
					send_request(ACT_BEGIN, RW_W'($urandom_range(1, 512)),
						RH_W'($urandom_range(1, 4096)));
				else if (pick < 15)
					send_request(ACT_PLACE, RW_W'($urandom_range(1, 512)),
						RH_W'($urandom_range(1, 4096)));
				else
					send_request(ACT_PLACE, RW_W'($urandom_range(1, wmax)),
						RH_W'($urandom_range(1, hmax)));
			end
			steady = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 28);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (placements_due.size() == 0) begin
				$error("result with no request pending");
				mismatches++;
			end else begin
				due_now = placements_due.pop_front();
				if (status !== due_now.status) begin
					$error("status: expected %0d, got %0d", due_now.status, status);
					mismatches++;
				end
				if (page !== due_now.page) begin
					$error("page: expected %0d, got %0d", due_now.page, page);
					mismatches++;
				end
				if (pos_x !== due_now.pos_x) begin
					$error("pos_x: expected %0d, got %0d", due_now.pos_x, pos_x);
					mismatches++;
				end
				if (pos_y !== due_now.pos_y) begin
					$error("pos_y: expected %0d, got %0d", due_now.pos_y, pos_y);
					mismatches++;
				end
				if (new_page !== due_now.new_page) begin
					$error("new_page: expected %0d, got %0d", due_now.new_page, new_page);
					mismatches++;
				end
			end
		end
	end

	// Drop the run when neither channel nor the register port moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PAGE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_PLACE;
		req_width = '0;
		req_height = '0;
		out_stall = 1'b0;
		cfg_page_width = PAGE_WIDTH_RST;
		cfg_page_height = PAGE_HEIGHT_RST;
		cfg_page_limit = PAGE_LIMIT_RST;
		page_now = FIRST_PAGE;
		clear_skyline();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_begin_request();
		test_special_cases();
		test_extremes();
		test_page_wrap();
		test_random_traffic();
		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && placements_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
